### rtl/core/tlt_pkg.sv
`default_nettype none
package tlt_pkg;

   localparam logic [30:0] HALF_WIDTH_RESET = 31'd32768;
   localparam int QUEUE_DEPTH = 2;

   // vertex k takes the end point when bit k is set, adds the offset when bit k is set
   localparam logic [5:0] VSEL_END = 6'b110100;
   localparam logic [5:0] VSEL_ADD = 6'b010101;

   typedef struct packed {
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] ex;
      logic [31:0] ey;
      logic [32:0] dx;
      logic [32:0] dy;
      logic        degen;
   } seg_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_ABS,
      B_NORM,
      B_SQA,
      B_SQB,
      B_SQRT,
      B_MUL,
      B_DIV,
      B_OFS,
      B_EMIT
   } back_state_type;

   function automatic logic [31:0] sat_34(input logic signed [33:0] v);
      logic [31:0] r;
      if (v > 34'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -34'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/core/tlt_channels.sv
`default_nettype none
interface tlt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] start_x;
   logic [31:0] start_y;
   logic [31:0] end_x;
   logic [31:0] end_y;
   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface tlt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] vertex_x;
   logic [31:0] vertex_y;
   logic        degenerate;
   logic        last_vertex;
   modport source (output valid, vertex_x, vertex_y, degenerate, last_vertex, input ready);
   modport sink (input valid, vertex_x, vertex_y, degenerate, last_vertex, output ready);
endinterface
`default_nettype wire

### rtl/core/thick_line_triangulator_core.sv
// each segment passes the back end's abs, normalize, square, square root, multiply, divide
//   and offset steps, then six vertices, one per cycle while rsp_ch.ready lets the output move;
//   a degenerate segment goes straight to the six vertices; the normalize, square root and
//   divide loops are bit-serial, and the back end takes a new segment only when idle
// a two-entry queue lets the front accept segments while the back end works
// reset: synchronous active-high, clears queue, sequencer and output valid, half width to 32768
`default_nettype none
module thick_line_triangulator_core
   import tlt_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata,
   tlt_req_if.sink          req_ch,
   tlt_rsp_if.source        rsp_ch
);

   logic [30:0] hw_ff;
   logic        f_valid, f_ready;
   seg_type     f_data;
   logic        b_valid, b_ready;
   seg_type     b_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff <= HALF_WIDTH_RESET;
      end else if (csr_we) begin
         hw_ff <= csr_wdata[30:0];
      end
   end

   tlt_front u_front (
      .req_ch  (req_ch),
      .q_ready (f_ready),
      .q_valid (f_valid),
      .q_data  (f_data)
   );

   tlt_fifo #(.DEPTH(QUEUE_DEPTH_P)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data)
   );

   tlt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .half_width (hw_ff),
      .q_valid    (b_valid),
      .q_ready    (b_ready),
      .q_data     (b_data),
      .rsp_ch     (rsp_ch)
   );

endmodule
`default_nettype wire

### rtl/core/tlt_front.sv
`default_nettype none
module tlt_front
   import tlt_pkg::*;
(
   tlt_req_if.sink req_ch,
   input  wire logic    q_ready,
   output logic         q_valid,
   output seg_type      q_data
);

   logic signed [32:0] dx;
   logic signed [32:0] dy;

   always_comb begin
      dx = $signed({req_ch.end_x[31], req_ch.end_x})
         - $signed({req_ch.start_x[31], req_ch.start_x});
      dy = $signed({req_ch.end_y[31], req_ch.end_y})
         - $signed({req_ch.start_y[31], req_ch.start_y});
      q_data.sx    = req_ch.start_x;
      q_data.sy    = req_ch.start_y;
      q_data.ex    = req_ch.end_x;
      q_data.ey    = req_ch.end_y;
      q_data.dx    = dx;
      q_data.dy    = dy;
      q_data.degen = (dx == 33'sd0) && (dy == 33'sd0);
   end

   assign q_valid      = req_ch.valid;
   assign req_ch.ready = q_ready;

endmodule
`default_nettype wire

### rtl/core/tlt_fifo.sv
`default_nettype none
module tlt_fifo
   import tlt_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire seg_type push_data,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output seg_type      pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   seg_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign push_ready = (cnt_ff != FULL);
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = do_push ? ((wr_ff == LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### rtl/core/tlt_back.sv
`default_nettype none
module tlt_back
   import tlt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [30:0] half_width,
   input  wire logic        q_valid,
   output logic             q_ready,
   input  wire seg_type     q_data,
   tlt_rsp_if.source        rsp_ch
);

   back_state_type     state_ff, state_in;
   seg_type            ent_ff;
   logic [32:0]        ax_ff, ay_ff;
   logic [61:0]        sq_ff;
   logic [62:0]        n_ff;
   logic [63:0]        res_ff;
   logic [62:0]        bit_ff;
   logic [31:0]        len;
   logic [62:0]        numx, numy;
   logic [32:0]        remx_ff, remy_ff;
   logic [31:0]        shx_ff, shy_ff;
   logic [31:0]        qx_ff, qy_ff;
   logic [4:0]         cnt_ff;
   logic signed [32:0] ox_ff, oy_ff;
   logic [2:0]         vcnt_ff;
   logic [32:0]        or_ab;
   logic [63:0]        trial;
   logic [32:0]        tx, ty;
   logic               out_free;
   logic               load;
   logic               vend, vadd;
   logic signed [33:0] px, py, vx, vy;

   logic        rsp_valid_ff;
   logic [31:0] rsp_x_ff, rsp_y_ff;
   logic        rsp_degen_ff, rsp_last_ff;

   assign len      = res_ff[31:0];
   assign or_ab    = ax_ff | ay_ff;
   assign trial    = res_ff + {1'b0, bit_ff};
   assign tx       = {remx_ff[31:0], shx_ff[31]};
   assign ty       = {remy_ff[31:0], shy_ff[31]};
   assign numx     = 63'(ay_ff[30:0] * half_width) + 63'(len >> 1);
   assign numy     = 63'(ax_ff[30:0] * half_width) + 63'(len >> 1);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (q_valid) state_in = q_data.degen ? B_EMIT : B_ABS;
         B_ABS:  state_in = B_NORM;
         B_NORM: begin
            if (or_ab[32:31] == 2'b00 && or_ab[30]) state_in = B_SQA;
         end
         B_SQA:  state_in = B_SQB;
         B_SQB:  state_in = B_SQRT;
         B_SQRT: if (bit_ff[62:2] == '0) state_in = B_MUL;
         B_MUL:  state_in = B_DIV;
         B_DIV:  if (cnt_ff == 5'd31) state_in = B_OFS;
         B_OFS:  state_in = B_EMIT;
         B_EMIT: if (out_free && vcnt_ff == 3'd5) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_ready = (state_ff == B_IDLE);
      load    = (state_ff == B_EMIT) && out_free;
      vend    = VSEL_END[vcnt_ff];
      vadd    = VSEL_ADD[vcnt_ff];
      px      = vend ? $signed({{2{ent_ff.ex[31]}}, ent_ff.ex})
                     : $signed({{2{ent_ff.sx[31]}}, ent_ff.sx});
      py      = vend ? $signed({{2{ent_ff.ey[31]}}, ent_ff.ey})
                     : $signed({{2{ent_ff.sy[31]}}, ent_ff.sy});
      vx      = vadd ? px + 34'(ox_ff) : px - 34'(ox_ff);
      vy      = vadd ? py + 34'(oy_ff) : py - 34'(oy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            ent_ff  <= q_data;
            ox_ff   <= '0;
            oy_ff   <= '0;
            vcnt_ff <= '0;
         end
         B_ABS: begin
            ax_ff <= ent_ff.dx[32] ? 33'(-ent_ff.dx) : ent_ff.dx;
            ay_ff <= ent_ff.dy[32] ? 33'(-ent_ff.dy) : ent_ff.dy;
         end
         B_NORM: begin
            if (or_ab[32:31] != 2'b00) begin
               ax_ff <= ax_ff >> 1;
               ay_ff <= ay_ff >> 1;
            end else if (!or_ab[30]) begin
               ax_ff <= ax_ff << 1;
               ay_ff <= ay_ff << 1;
            end
         end
         B_SQA: sq_ff <= ax_ff[30:0] * ax_ff[30:0];
         B_SQB: begin
            n_ff   <= 63'(sq_ff) + 63'(ay_ff[30:0] * ay_ff[30:0]);
            res_ff <= '0;
            bit_ff <= 63'd1 << 62;
         end
         B_SQRT: begin
            if ({1'b0, n_ff} >= trial) begin
               n_ff   <= 63'({1'b0, n_ff} - trial);
               res_ff <= (res_ff >> 1) + {1'b0, bit_ff};
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         B_MUL: begin
            remx_ff <= {2'b00, numx[62:32]};
            remy_ff <= {2'b00, numy[62:32]};
            shx_ff  <= numx[31:0];
            shy_ff  <= numy[31:0];
            cnt_ff  <= '0;
         end
         B_DIV: begin
            if (tx >= {1'b0, len}) begin
               remx_ff <= tx - {1'b0, len};
               qx_ff   <= {qx_ff[30:0], 1'b1};
            end else begin
               remx_ff <= tx;
               qx_ff   <= {qx_ff[30:0], 1'b0};
            end
            if (ty >= {1'b0, len}) begin
               remy_ff <= ty - {1'b0, len};
               qy_ff   <= {qy_ff[30:0], 1'b1};
            end else begin
               remy_ff <= ty;
               qy_ff   <= {qy_ff[30:0], 1'b0};
            end
            shx_ff <= shx_ff << 1;
            shy_ff <= shy_ff << 1;
            cnt_ff <= cnt_ff + 5'd1;
         end
         B_OFS: begin
            ox_ff <= ent_ff.dy[32] ? -$signed({1'b0, qx_ff}) : $signed({1'b0, qx_ff});
            oy_ff <= (!ent_ff.dx[32] && ent_ff.dx != '0) ? -$signed({1'b0, qy_ff})
                                                           : $signed({1'b0, qy_ff});
         end
         B_EMIT: begin
            if (load) begin
               rsp_x_ff     <= sat_34(vx);
               rsp_y_ff     <= sat_34(vy);
               rsp_degen_ff <= ent_ff.degen;
               rsp_last_ff  <= (vcnt_ff == 3'd5);
               vcnt_ff      <= vcnt_ff + 3'd1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.vertex_x    = rsp_x_ff;
   assign rsp_ch.vertex_y    = rsp_y_ff;
   assign rsp_ch.degenerate  = rsp_degen_ff;
   assign rsp_ch.last_vertex = rsp_last_ff;

endmodule
`default_nettype wire
